// File: hw/rtl/gnt_pkg.sv
// Shared types and constants for the neighbour table next-hop core.
// No dependencies; imported by the front, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none
package gnt_pkg;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_DEL    = 3'd1,
		OP_GETPOS = 3'd2,
		OP_ISNB   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_GREEDY = 3'd5,
		OP_PERIM  = 3'd6,
		OP_UPTIME = 3'd7
	} op_t;

	// Command class produced by the front end.
	typedef struct packed {
		op_t  op;
		logic purge;
		logic geo;
	} cmd_class_t;

	localparam int CLASS_W = $bits(cmd_class_t);
	localparam int TIME_W  = 32;
	localparam int ADDR_W  = 32;
	localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd2000;

endpackage
`default_nettype wire

// File: hw/rtl/geo_neighbour_table_next_hop_core.sv
// Top level of the neighbour table next-hop core.
// Instantiates gnt_front, gnt_cmd_queue and gnt_back; uses gnt_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Command channel: drive func, now_time, key_addr and the position fields
//  and raise start; the word is taken at an edge where start is high and
//  busy is low. The front end registers and classifies the word, then hands
//  it to a two-deep queue, so up to three words can wait behind the one the
//  back end is working on.
//  Config channel: cfg_valid/cfg_ready/cfg_wdata write entry_lifetime;
//  cfg_ready is always high. Write it only while the core is idle.
//  Result channel: done pulses for one cycle with found, hop_addr, out_x,
//  out_y, stamp_out and table_full. The receiver cannot stall; sample it.
//  Processing: clear skips the table walk; add, delete, lookups
//  and is-neighbour do one table read and one check per entry; greedy and
//  perimeter also use the shared multiplier pair, which forms the distance
//  or two cross products and a dot product of each live entry in turn.
//  With words queued behind the current one, the back end takes the next
//  word as soon as it returns to idle.
//  Reset: all entries go invalid and entry_lifetime returns to 2000; the
//  core is ready to take a word right after reset.
module geo_neighbour_table_next_hop_core #(
	parameter int ENTRIES    = 16,
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    func,
	input  logic [gnt_pkg::TIME_W-1:0]    now_time,
	input  logic [gnt_pkg::ADDR_W-1:0]    key_addr,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic signed [COORD_BITS-1:0]  self_x,
	input  logic signed [COORD_BITS-1:0]  self_y,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gnt_pkg::TIME_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic                          found,
	output logic [gnt_pkg::ADDR_W-1:0]    hop_addr,
	output logic signed [COORD_BITS-1:0]  out_x,
	output logic signed [COORD_BITS-1:0]  out_y,
	output logic [gnt_pkg::TIME_W-1:0]    stamp_out,
	output logic                          table_full
);
	import gnt_pkg::*;

	// queue word: class, time, key, pos, reference point, two offsets
	localparam int W = CLASS_W + TIME_W + ADDR_W + 6 * COORD_BITS + 2;

	logic [TIME_W-1:0] lifetime_q;
	logic              push, q_full, q_empty, pop;
	logic [W-1:0]      f_word, q_word;

	// hold the lifetime register; accept every config word
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			lifetime_q <= cfg_wdata;
		end
	end

	// accept and classify the command word
	gnt_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.now_time (now_time),
		.key_addr (key_addr),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.self_x   (self_x),
		.self_y   (self_y),
		.q_full   (q_full),
		.push     (push),
		.word     (f_word)
	);

	// decouple front and back
	gnt_cmd_queue #(
		.W(W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_word),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_word),
		.empty  (q_empty)
	);

	// walk the table and produce the result word
	gnt_back #(
		.ENTRIES    (ENTRIES),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_word),
		.pop        (pop),
		.lifetime   (lifetime_q),
		.done       (done),
		.found      (found),
		.hop_addr   (hop_addr),
		.out_x      (out_x),
		.out_y      (out_y),
		.stamp_out  (stamp_out),
		.table_full (table_full)
	);

endmodule
`default_nettype wire

// File: hw/rtl/gnt_front.sv
// Front end: takes command words, classifies them and precomputes the
// reference point and the direction or offset vector. Uses gnt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gnt_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [2:0]                            func,
	input  logic [gnt_pkg::TIME_W-1:0]            now_time,
	input  logic [gnt_pkg::ADDR_W-1:0]            key_addr,
	input  logic signed [COORD_BITS-1:0]          pos_x,
	input  logic signed [COORD_BITS-1:0]          pos_y,
	input  logic signed [COORD_BITS-1:0]          self_x,
	input  logic signed [COORD_BITS-1:0]          self_y,
	input  logic                                  q_full,
	output logic                                  push,
	output logic [gnt_pkg::CLASS_W+gnt_pkg::TIME_W+gnt_pkg::ADDR_W
		+6*COORD_BITS+2-1:0]                      word
);
	import gnt_pkg::*;

	localparam int C = COORD_BITS;
	localparam int D = C + 1;
	localparam int W = CLASS_W + TIME_W + ADDR_W + 6 * C + 2;

	cmd_class_t             cls;
	logic signed [C-1:0]    ref_x, ref_y;
	logic signed [D-1:0]    d0, d1;
	logic                   take;
	logic                   vld_s1;
	logic [W-1:0]           word_s1;

	always_comb begin
		cls.op    = op_t'(func);
		cls.purge = (cls.op == OP_ISNB) || (cls.op == OP_GREEDY) || (cls.op == OP_PERIM);
		cls.geo   = (cls.op == OP_GREEDY) || (cls.op == OP_PERIM);
		// perimeter measures from own node, everything else from pos
		if (cls.op == OP_PERIM) begin
			ref_x = self_x;
			ref_y = self_y;
			d0    = {pos_x[C-1], pos_x} - {self_x[C-1], self_x};
			d1    = {pos_y[C-1], pos_y} - {self_y[C-1], self_y};
		end else begin
			ref_x = pos_x;
			ref_y = pos_y;
			d0    = {self_x[C-1], self_x} - {pos_x[C-1], pos_x};
			d1    = {self_y[C-1], self_y} - {pos_y[C-1], pos_y};
		end
	end

	assign push = vld_s1 && !q_full;
	assign busy = vld_s1 && q_full;
	assign take = start && !busy;
	assign word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= {cls, now_time, key_addr, pos_x, pos_y, ref_x, ref_y, d0, d1};
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/gnt_cmd_queue.sv
// Two-deep command queue between the front and back ends.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gnt_cmd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/gnt_back.sv
// Back end: walks the neighbour table one entry at a time, purges stale
// entries for is-neighbour, greedy and perimeter, and runs the lookup, greedy or perimeter selection. Uses gnt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gnt_back #(
	parameter int ENTRIES    = 16,
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	input  logic [gnt_pkg::CLASS_W+gnt_pkg::TIME_W+gnt_pkg::ADDR_W
		+6*COORD_BITS+2-1:0]                      q_data,
	output logic                                  pop,
	input  logic [gnt_pkg::TIME_W-1:0]            lifetime,
	output logic                                  done,
	output logic                                  found,
	output logic [gnt_pkg::ADDR_W-1:0]            hop_addr,
	output logic signed [COORD_BITS-1:0]          out_x,
	output logic signed [COORD_BITS-1:0]          out_y,
	output logic [gnt_pkg::TIME_W-1:0]            stamp_out,
	output logic                                  table_full
);
	import gnt_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int MW = 2 * D + 1;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0]       LAST_IDX   = IW'(ENTRIES - 1);
	localparam logic signed [C-1:0] ABSENT_POS = C'(-16);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_OWN  = 9'b000000010,
		ST_RD   = 9'b000000100,
		ST_LD   = 9'b000001000,
		ST_M1   = 9'b000010000,
		ST_M2   = 9'b000100000,
		ST_M3   = 9'b001000000,
		ST_DEC  = 9'b010000000,
		ST_END  = 9'b100000000
	} state_t;

	// queue word fields
	cmd_class_t          cls_c;
	logic [TIME_W-1:0]   now_c;
	logic [ADDR_W-1:0]   key_c;
	logic signed [C-1:0] px_c, py_c, rx_c, ry_c;
	logic signed [D-1:0] d0_c, d1_c;

	assign {cls_c, now_c, key_c, px_c, py_c, rx_c, ry_c, d0_c, d1_c} = q_data;

	state_t              st_q;
	op_t                 op_q;
	logic                purge_q;
	logic [TIME_W-1:0]   now_q;
	logic [ADDR_W-1:0]   key_q;
	logic signed [C-1:0] px_q, py_q, rx_q, ry_q;
	logic signed [D-1:0] d0_q, d1_q;

	logic [IW-1:0]       idx_q;
	logic [ENTRIES-1:0]  valid_q;

	// table storage and registered read port
	logic [ADDR_W-1:0]   mem_key   [ENTRIES];
	logic [TIME_W-1:0]   mem_stamp [ENTRIES];
	logic signed [C-1:0] mem_x     [ENTRIES];
	logic signed [C-1:0] mem_y     [ENTRIES];
	logic [ADDR_W-1:0]   ent_key_q;
	logic [TIME_W-1:0]   ent_stamp_q;
	logic signed [C-1:0] ent_x_q, ent_y_q;

	// scan trackers
	logic                hit_q, free_q;
	logic [IW-1:0]       hit_idx_q, free_idx_q;
	logic signed [C-1:0] cap_x_q, cap_y_q;
	logic [TIME_W-1:0]   cap_stamp_q;
	logic signed [D-1:0] a0_q, a1_q, bax_q, bay_q;
	logic signed [MW-1:0] res1_q, res2_q, res3_q, own_q, bd_q;
	logic                best_q, bh_q, low_q;
	logic [ADDR_W-1:0]   bkey_q, lkey_q;

	logic                done_q, found_q, full_q;
	logic [ADDR_W-1:0]   hop_q;
	logic signed [C-1:0] ox_q, oy_q;
	logic [TIME_W-1:0]   stamp_q;

	// per-entry decode
	logic                cur_valid, expired, drop, ev, km, at_self, cz, last;
	logic signed [D-1:0] ea0, ea1;
	logic                wr_en;
	logic [IW-1:0]       wr_idx;

	// shared multiplier pair
	logic signed [D-1:0]    opa0, opb0, opa1, opb1;
	logic                   msub;
	logic signed [2*D-1:0]  p0, p1;
	logic signed [MW-1:0]   mres;

	// perimeter decision
	logic                h_cur, g_better, p_skip, p_better, g_found;

	assign pop = (st_q == ST_IDLE) && !q_empty;

	always_comb begin
		cur_valid = valid_q[idx_q];
		expired   = ({1'b0, ent_stamp_q} + {1'b0, lifetime}) <= {1'b0, now_q};
		drop      = purge_q && cur_valid && ((ent_key_q == '0) || expired);
		ev        = cur_valid && !drop;
		km        = ev && (ent_key_q == key_q);
		ea0       = {ent_x_q[C-1], ent_x_q} - {rx_q[C-1], rx_q};
		ea1       = {ent_y_q[C-1], ent_y_q} - {ry_q[C-1], ry_q};
		at_self   = (ent_x_q == rx_q) && (ent_y_q == ry_q);
		cz        = (d0_q == '0) && (d1_q == '0);
		last      = (idx_q == LAST_IDX);
		wr_en     = (st_q == ST_END) && (op_q == OP_ADD) && (hit_q || free_q);
		wr_idx    = hit_q ? hit_idx_q : free_idx_q;
	end

	always_comb begin
		case (st_q)
			ST_M1: begin
				if (op_q == OP_GREEDY) begin
					opa0 = a0_q; opb0 = a0_q; opa1 = a1_q; opb1 = a1_q; msub = 1'b0;
				end else begin
					opa0 = d0_q; opb0 = a1_q; opa1 = d1_q; opb1 = a0_q; msub = 1'b1;
				end
			end
			ST_M2: begin
				opa0 = d0_q; opb0 = a0_q; opa1 = d1_q; opb1 = a1_q; msub = 1'b0;
			end
			ST_M3: begin
				opa0 = bax_q; opb0 = a1_q; opa1 = bay_q; opb1 = a0_q; msub = 1'b1;
			end
			default: begin
				opa0 = d0_q; opb0 = d0_q; opa1 = d1_q; opb1 = d1_q; msub = 1'b0;
			end
		endcase
		p0   = opa0 * opb0;
		p1   = opa1 * opb1;
		mres = msub ? (MW'(p0) - MW'(p1)) : (MW'(p0) + MW'(p1));
	end

	always_comb begin
		g_better = !best_q || (res1_q < bd_q) || ((res1_q == bd_q) && (ent_key_q < bkey_q));
		h_cur    = res1_q[MW-1];
		p_skip   = (res1_q == '0) && (res2_q > 0);
		if (!best_q) begin
			p_better = 1'b1;
		end else if (h_cur != bh_q) begin
			p_better = h_cur && !bh_q;
		end else begin
			p_better = (res3_q > 0) || ((res3_q == '0) && (ent_key_q < bkey_q));
		end
		g_found = best_q && (bd_q < own_q);
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (st_q == ST_RD) begin
			ent_key_q   <= mem_key[idx_q];
			ent_stamp_q <= mem_stamp[idx_q];
			ent_x_q     <= mem_x[idx_q];
			ent_y_q     <= mem_y[idx_q];
		end
		if (wr_en) begin
			mem_key[wr_idx]   <= key_q;
			mem_stamp[wr_idx] <= now_q;
			mem_x[wr_idx]     <= px_q;
			mem_y[wr_idx]     <= py_q;
		end
	end

	// command payload and per-entry work registers
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q    <= cls_c.op;
			purge_q <= cls_c.purge;
			now_q   <= now_c;
			key_q   <= key_c;
			px_q    <= px_c;
			py_q    <= py_c;
			rx_q    <= rx_c;
			ry_q    <= ry_c;
			d0_q    <= d0_c;
			d1_q    <= d1_c;
		end
		if (st_q == ST_LD) begin
			a0_q <= ea0;
			a1_q <= ea1;
		end
		if (st_q == ST_OWN) begin
			own_q <= mres;
		end
		if (st_q == ST_M1) begin
			res1_q <= mres;
		end
		if (st_q == ST_M2) begin
			res2_q <= mres;
		end
		if (st_q == ST_M3) begin
			res3_q <= mres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= '0;
			valid_q     <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			hit_idx_q   <= '0;
			free_idx_q  <= '0;
			cap_x_q     <= '0;
			cap_y_q     <= '0;
			cap_stamp_q <= '0;
			best_q      <= 1'b0;
			bh_q        <= 1'b0;
			low_q       <= 1'b0;
			bkey_q      <= '0;
			lkey_q      <= '0;
			bd_q        <= '0;
			bax_q       <= '0;
			bay_q       <= '0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
			full_q      <= 1'b0;
			hop_q       <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			stamp_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						idx_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						best_q <= 1'b0;
						bh_q   <= 1'b0;
						low_q  <= 1'b0;
						if (cls_c.op == OP_CLEAR) begin
							valid_q <= '0;
							st_q    <= ST_END;
						end else if (cls_c.op == OP_GREEDY) begin
							st_q <= ST_OWN;
						end else begin
							st_q <= ST_RD;
						end
					end
				end
				ST_OWN: begin
					st_q <= ST_RD;
				end
				ST_RD: begin
					st_q <= ST_LD;
				end
				ST_LD: begin
					if (drop) begin
						valid_q[idx_q] <= 1'b0;
					end
					if (km && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
						cap_x_q   <= ent_x_q;
						cap_y_q   <= ent_y_q;
						if (op_q == OP_DEL) begin
							valid_q[idx_q] <= 1'b0;
						end
						if (op_q == OP_UPTIME && key_q != '0) begin
							cap_stamp_q <= ent_stamp_q;
						end
					end
					if (!cur_valid && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (op_q == OP_PERIM && ev && (!low_q || ent_key_q < lkey_q)) begin
						low_q  <= 1'b1;
						lkey_q <= ent_key_q;
					end
					if ((op_q == OP_GREEDY && ev) ||
						(op_q == OP_PERIM && ev && !at_self && !cz)) begin
						st_q <= ST_M1;
					end else if (last) begin
						st_q <= ST_END;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= ST_RD;
					end
				end
				ST_M1: begin
					st_q <= (op_q == OP_GREEDY) ? ST_DEC : ST_M2;
				end
				ST_M2: begin
					st_q <= ST_M3;
				end
				ST_M3: begin
					st_q <= ST_DEC;
				end
				ST_DEC: begin
					if (op_q == OP_GREEDY) begin
						if (g_better) begin
							best_q <= 1'b1;
							bkey_q <= ent_key_q;
							bd_q   <= res1_q;
						end
					end else if (!p_skip && p_better) begin
						best_q <= 1'b1;
						bkey_q <= ent_key_q;
						bh_q   <= h_cur;
						bax_q  <= a0_q;
						bay_q  <= a1_q;
					end
					if (last) begin
						st_q <= ST_END;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= ST_RD;
					end
				end
				ST_END: begin
					done_q  <= 1'b1;
					found_q <= 1'b0;
					full_q  <= 1'b0;
					hop_q   <= '0;
					ox_q    <= '0;
					oy_q    <= '0;
					stamp_q <= '0;
					case (op_q)
						OP_ADD: begin
							found_q <= hit_q || free_q;
							full_q  <= !(hit_q || free_q);
							if (hit_q || free_q) begin
								valid_q[wr_idx] <= 1'b1;
							end
						end
						OP_DEL, OP_ISNB: begin
							found_q <= hit_q;
						end
						OP_GETPOS: begin
							found_q <= hit_q;
							ox_q    <= hit_q ? cap_x_q : ABSENT_POS;
							oy_q    <= hit_q ? cap_y_q : ABSENT_POS;
						end
						OP_CLEAR: begin
							found_q <= 1'b0;
						end
						OP_GREEDY: begin
							found_q <= g_found;
							hop_q   <= g_found ? bkey_q : '0;
						end
						OP_PERIM: begin
							found_q <= best_q || low_q;
							hop_q   <= best_q ? bkey_q : (low_q ? lkey_q : '0);
						end
						default: begin
							found_q <= hit_q && (key_q != '0);
							stamp_q <= (hit_q && key_q != '0) ? cap_stamp_q : '0;
						end
					endcase
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign hop_addr   = hop_q;
	assign out_x      = ox_q;
	assign out_y      = oy_q;
	assign stamp_out  = stamp_q;
	assign table_full = full_q;

	a_done_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(st_q == ST_END))
		else $error("result strobe without a finishing step");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && full_q) |-> !found_q)
		else $error("table full reported together with found");

	a_m2_after_m1: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_M2) |-> $past(st_q == ST_M1))
		else $error("second product step out of sequence");

endmodule
`default_nettype wire

// File: sim/geo_neighbour_table_next_hop_core_tb.sv
// Self-checking testbench for geo_neighbour_table_next_hop_core.
// Depends on gnt_pkg and the core RTL. A local table model predicts each result word.
`timescale 1ns / 1ps
module geo_neighbour_table_next_hop_core_tb;
	import gnt_pkg::*;

	localparam int ENTRIES = 16;
	localparam int CB      = 24;
	localparam int DRAIN   = 6 * ENTRIES + 20;

	typedef struct packed {
		logic          found;
		logic [31:0]   hop;
		logic [CB-1:0] ox;
		logic [CB-1:0] oy;
		logic [31:0]   stamp;
		logic          full;
	} hop_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [2:0]    func = '0;
	logic [31:0]   now_time = '0;
	logic [31:0]   key_addr = '0;
	logic [CB-1:0] pos_x = '0, pos_y = '0, self_x = '0, self_y = '0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [31:0]   cfg_wdata = '0;
	logic          done, found, table_full;
	logic [31:0]   hop_addr, stamp_out;
	logic [CB-1:0] out_x, out_y;

	geo_neighbour_table_next_hop_core #(.ENTRIES(ENTRIES), .COORD_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.now_time(now_time), .key_addr(key_addr), .pos_x(pos_x), .pos_y(pos_y),
		.self_x(self_x), .self_y(self_y), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_wdata(cfg_wdata), .done(done), .found(found), .hop_addr(hop_addr),
		.out_x(out_x), .out_y(out_y), .stamp_out(stamp_out), .table_full(table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model copy of the neighbour table and the lifetime register.
	logic        nb_valid [ENTRIES];
	logic [31:0] nb_key   [ENTRIES];
	longint      nb_x     [ENTRIES];
	longint      nb_y     [ENTRIES];
	logic [31:0] nb_stamp [ENTRIES];
	logic [31:0] lifetime = LIFETIME_RST;

	hop_result_t pending_hops[$];
	int          mismatches = 0;
	logic [31:0] tick = 0;

	function automatic int lookup_slot(logic [31:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (nb_valid[i] && nb_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void drop_stale(logic [31:0] now);
		for (int i = 0; i < ENTRIES; i++)
			if (nb_valid[i] && (nb_key[i] == 0 ||
			    {1'b0, nb_stamp[i]} + {1'b0, lifetime} <= {1'b0, now}))
				nb_valid[i] = 1'b0;
	endfunction

	function automatic hop_result_t predict_hop(op_t op, logic [31:0] now, logic [31:0] k,
			logic signed [CB-1:0] px_i, logic signed [CB-1:0] py_i,
			logic signed [CB-1:0] sx_i, logic signed [CB-1:0] sy_i);
		hop_result_t r;
		int idx, best, low, bh, h;
		longint px, py, sx, sy, own, bd, d, dx, dy, cx, cy, ax, ay, wx, wy, bax, bay, cr;
		logic better;
		r = '0;
		px = px_i; py = py_i; sx = sx_i; sy = sy_i;
		best = -1; low = -1; bh = 0; bd = 0; bax = 0; bay = 0;
		case (op)
			OP_ADD: begin
				idx = lookup_slot(k);
				if (idx < 0)
					for (int i = 0; i < ENTRIES && idx < 0; i++)
						if (!nb_valid[i]) idx = i;
				if (idx < 0) r.full = 1'b1;
				else begin
					nb_valid[idx] = 1'b1; nb_key[idx] = k;
					nb_x[idx] = px; nb_y[idx] = py; nb_stamp[idx] = now;
					r.found = 1'b1;
				end
			end
			OP_DEL: begin
				idx = lookup_slot(k);
				if (idx >= 0) begin
					nb_valid[idx] = 1'b0;
					r.found = 1'b1;
				end
			end
			OP_GETPOS: begin
				idx = lookup_slot(k);
				if (idx >= 0) begin
					r.found = 1'b1;
					r.ox = nb_x[idx][CB-1:0];
					r.oy = nb_y[idx][CB-1:0];
				end else begin
					r.ox = CB'(-16);
					r.oy = CB'(-16);
				end
			end
			OP_ISNB: begin
				drop_stale(now);
				r.found = lookup_slot(k) >= 0;
			end
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++) nb_valid[i] = 1'b0;
			end
			OP_GREEDY: begin
				dx = sx - px; dy = sy - py;
				own = dx * dx + dy * dy;
				drop_stale(now);
				for (int i = 0; i < ENTRIES; i++) begin
					if (!nb_valid[i]) continue;
					dx = nb_x[i] - px; dy = nb_y[i] - py;
					d = dx * dx + dy * dy;
					if (best < 0 || d < bd || (d == bd && nb_key[i] < nb_key[best])) begin
						best = i; bd = d;
					end
				end
				if (best >= 0 && bd < own) begin
					r.found = 1'b1;
					r.hop = nb_key[best];
				end
			end
			OP_PERIM: begin
				cx = px - sx; cy = py - sy;
				drop_stale(now);
				for (int i = 0; i < ENTRIES; i++) begin
					if (!nb_valid[i]) continue;
					if (low < 0 || nb_key[i] < nb_key[low]) low = i;
					ax = nb_x[i] - sx; ay = nb_y[i] - sy;
					if ((ax == 0 && ay == 0) || (cx == 0 && cy == 0)) continue;
					wy = cx * ay - cy * ax;
					wx = cx * ax + cy * ay;
					// skip a neighbour lying exactly along the previous-hop direction
					if (wy == 0 && wx > 0) continue;
					h = wy < 0 ? 1 : 0;
					if (best < 0) better = 1'b1;
					else if (h != bh) better = h > bh;
					else begin
						cr = bax * ay - bay * ax;
						better = cr > 0 || (cr == 0 && nb_key[i] < nb_key[best]);
					end
					if (better) begin
						best = i; bh = h; bax = ax; bay = ay;
					end
				end
				if (best < 0) best = low;
				if (best >= 0) begin
					r.found = 1'b1;
					r.hop = nb_key[best];
				end
			end
			default: begin
				idx = (k == 0) ? -1 : lookup_slot(k);
				if (idx >= 0) begin
					r.found = 1'b1;
					r.stamp = nb_stamp[idx];
				end
			end
		endcase
		return r;
	endfunction

	// Sample results mid-cycle, clear of the edge where they change.
	always @(negedge clk) begin
		hop_result_t want, got;
		if (arst_n && done) begin
			got = {found, hop_addr, out_x, out_y, stamp_out, table_full};
			if (pending_hops.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				want = pending_hops.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp f=%b hop=%h x=%h y=%h st=%h full=%b | act f=%b hop=%h x=%h y=%h st=%h full=%b",
							want.found, want.hop, want.ox, want.oy, want.stamp, want.full,
							got.found, got.hop, got.ox, got.oy, got.stamp, got.full);
				end
			end
		end
	end

	// Hold start across back-to-back words; drop it only for a real gap.
	task automatic send_word(op_t op, logic [31:0] now, logic [31:0] k,
			logic [CB-1:0] px, logic [CB-1:0] py, logic [CB-1:0] sx, logic [CB-1:0] sy);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= op; now_time <= now; key_addr <= k;
		pos_x <= px; pos_y <= py; self_x <= sx; self_y <= sy;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				pending_hops.push_back(predict_hop(op, now, k, px, py, sx, sy));
				break;
			end
			@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		wait (pending_hops.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_lifetime(logic [31:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_wdata <= v;
		forever begin
			@(negedge clk);
			if (cfg_ready) begin
				@(posedge clk);
				lifetime = v;
				break;
			end
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CB-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return CB'($urandom);
			1, 2: return CB'($signed($urandom_range(0, 16)) - 8);
			default: return CB'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $urandom_range(0, 24);
	endfunction

	task automatic test_basic_ops();
		send_word(OP_GETPOS, 0, 5, 0, 0, 0, 0);
		send_word(OP_ADD, 10, 5, 24'h7FFFFF, 24'h800000, 0, 0);
		send_word(OP_ADD, 11, 0, 24'h000010, 24'hFFFFF0, 0, 0);
		send_word(OP_ADD, 12, 32'hFFFFFFFF, 24'h800000, 24'h7FFFFF, 0, 0);
		send_word(OP_GETPOS, 13, 5, 0, 0, 0, 0);
		send_word(OP_GETPOS, 13, 0, 0, 0, 0, 0);
		send_word(OP_UPTIME, 14, 0, 0, 0, 0, 0);
		send_word(OP_UPTIME, 14, 32'hFFFFFFFF, 0, 0, 0, 0);
		send_word(OP_ADD, 20, 5, 24'h000100, 24'h000100, 0, 0);
		send_word(OP_UPTIME, 21, 5, 0, 0, 0, 0);
		send_word(OP_ISNB, 22, 0, 0, 0, 0, 0);
		send_word(OP_GREEDY, 23, 0, 24'h000100, 24'h000100, 24'h7FFFFF, 24'h7FFFFF);
		send_word(OP_PERIM, 24, 0, 24'h000010, 0, 0, 0);
		// previous hop at own position: fall back to lowest address
		send_word(OP_PERIM, 24, 0, 0, 0, 0, 0);
		send_word(OP_DEL, 25, 5, 0, 0, 0, 0);
		send_word(OP_DEL, 25, 5, 0, 0, 0, 0);
		send_word(OP_CLEAR, 26, 0, 0, 0, 0, 0);
		send_word(OP_GREEDY, 27, 0, 0, 0, 0, 0);
		send_word(OP_PERIM, 27, 0, 0, 0, 0, 0);
	endtask

	task automatic test_table_full();
		for (int i = 1; i <= ENTRIES + 2; i++)
			send_word(OP_ADD, 100, i, pick_coord(), pick_coord(), 0, 0);
		send_word(OP_ADD, 101, 3, 0, 0, 0, 0);
		send_word(OP_ISNB, 102, ENTRIES, 0, 0, 0, 0);
	endtask

	task automatic test_lifetime_edges();
		write_lifetime(0);
		send_word(OP_ADD, 500, 7, 0, 0, 0, 0);
		send_word(OP_ISNB, 500, 7, 0, 0, 0, 0);
		write_lifetime(32'hFFFFFFFF);
		send_word(OP_ADD, 32'hFFFFFFFF, 8, 0, 0, 0, 0);
		send_word(OP_ISNB, 32'hFFFFFFFF, 8, 0, 0, 0, 0);
		send_word(OP_ADD, 0, 9, 0, 0, 0, 0);
		send_word(OP_ISNB, 32'hFFFFFFFF, 9, 0, 0, 0, 0);
		send_word(OP_GREEDY, 32'hFFFFFFFF, 0, 5, 5, 24'h7FFFFF, 24'h7FFFFF);
	endtask

	task automatic test_random(int n);
		op_t op;
		logic [31:0] now;
		for (int i = 0; i < n; i++) begin
			tick += $urandom_range(0, 300);
			now = ($urandom_range(0, 19) == 0) ? $urandom : tick;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: op = OP_ADD;
				6, 7: op = OP_DEL;
				8, 9: op = OP_GETPOS;
				10: op = OP_ISNB;
				11: op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_UPTIME;
				12, 13, 14: op = OP_GREEDY;
				15, 16, 17: op = OP_PERIM;
				default: op = op_t'($urandom_range(0, 7));
			endcase
			send_word(op, now, pick_key(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
		end
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) nb_valid[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_table_full();
		test_lifetime_edges();
		write_lifetime(2000);
		test_random(350);
		write_lifetime(50);
		test_random(150);
		write_lifetime($urandom);
		test_random(150);
		write_lifetime(32'hFFFFFFFF);
		test_random(150);
		write_lifetime(0);
		test_random(100);
		wait_idle();
		if (mismatches == 0 && pending_hops.size() == 0)
			$display("geo_neighbour_table_next_hop_core regression: pass");
		else
			$display("geo_neighbour_table_next_hop_core regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("geo_neighbour_table_next_hop_core regression: fail");
		$finish;
	end
endmodule
